### sv/mhi_pkg.sv
// shared types and constants of the max-heap insert engine
// no dependencies; used by max_heap_insert_engine_unit, max_heap_insert_checker and the bench
package mhi_pkg;

   localparam int CAPACITY  = 16;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int KEY_W     = 32;
   localparam int POS_W     = 4;
   localparam int CNT_OUT_W = 5;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] new_key;
      logic [POS_W-1:0]        position;
   } mhi_req_type;

   typedef struct packed {
      logic                    accepted;
      logic signed [KEY_W-1:0] read_key;
      logic [CNT_OUT_W-1:0]    entry_count;
      logic signed [KEY_W-1:0] top_key;
   } mhi_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_PLACE,
      ST_RESP
   } mhi_state_type;

endpackage

### sv/max_heap_insert_engine_unit.sv
// max-heap insert engine: heap array in mhi_ram, sift-up sequencer, result register
// depends on mhi_pkg and mhi_ram
// paths to rsp_valid: insert into a non-empty heap stays in CMP while the parent is smaller
//   and not the root, then PLACE, RESP; empty heap PLACE, RESP; valid read READ, RESP;
//   refused ops RESP only; one transaction at a time, a waiting result holds RESP
// reset: synchronous, clears count, sequencer and result valid; heap ram keeps contents
module max_heap_insert_engine_unit
   import mhi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mhi_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mhi_rsp_type rsp_data
);

   mhi_state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       slot_ff, slot_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] top_ff, top_in;
   logic signed [KEY_W-1:0] rkey_ff, rkey_in;
   logic                    acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mhi_rsp_type             rsp_data_ff, rsp_data_in;

   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [KEY_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]       mem_raddr;
   logic [KEY_W-1:0]        mem_rdata;

   logic                    accept;
   logic                    full;
   logic [31:0]             pos_ext;
   logic                    pos_ok;
   logic [ADDR_W-1:0]       ins_slot;
   logic [ADDR_W-1:0]       ins_up;
   logic [ADDR_W-1:0]       up;
   logic [ADDR_W-1:0]       up_up;
   logic                    key_less;
   logic                    rsp_free;

   mhi_ram #(
      .WIDTH(KEY_W),
      .DEPTH(CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign pos_ext   = 32'(req_data.position);
   assign pos_ok    = (pos_ext < 32'(count_ff)) && (pos_ext < 32'(CAPACITY));
   assign ins_slot  = ADDR_W'(count_ff);
   assign ins_up    = (ins_slot - ADDR_W'(1)) >> 1;
   assign up        = (slot_ff - ADDR_W'(1)) >> 1;
   assign up_up     = (up - ADDR_W'(1)) >> 1;
   // parent strictly smaller moves down, equal parent stays
   assign key_less  = ($signed(mem_rdata) < key_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_INSERT) begin
                  if (full) begin
                     state_in = ST_RESP;
                  end else if (count_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_CMP;
                  end
               end else if (pos_ok) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_CMP: begin
            if (key_less && (up != '0)) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = key_ff;
      mem_raddr    = up;
      count_in     = count_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      top_in       = top_ff;
      acc_in       = acc_ff;
      rkey_in      = rkey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               acc_in  = 1'b0;
               rkey_in = '0;
               if (req_data.req_type == REQ_INSERT) begin
                  key_in = req_data.new_key;
                  if (!full) begin
                     count_in  = count_ff + CNT_W'(1);
                     slot_in   = ins_slot;
                     mem_raddr = ins_up;
                     acc_in    = 1'b1;
                  end
               end else begin
                  mem_raddr = ADDR_W'(pos_ext);
                  acc_in    = pos_ok;
               end
            end
         end
         ST_READ: begin
            rkey_in = mem_rdata;
         end
         ST_CMP: begin
            if (key_less) begin
               // move parent down and fetch the next parent in the same cycle
               mem_we    = 1'b1;
               mem_waddr = slot_ff;
               mem_wdata = mem_rdata;
               slot_in   = up;
               mem_raddr = up_up;
            end
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            mem_wdata = key_ff;
            if (slot_ff == '0) begin
               top_in = key_ff;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.accepted    = acc_ff;
               rsp_data_in.read_key    = rkey_ff;
               rsp_data_in.entry_count = CNT_OUT_W'(count_ff);
               rsp_data_in.top_key     = (count_ff != '0) ? top_ff : '0;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      key_ff      <= key_in;
      top_ff      <= top_in;
      acc_ff      <= acc_in;
      rkey_ff     <= rkey_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == REQ_INSERT) && !full)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("stored insert did not advance the count");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_CMP) || (state_ff == ST_PLACE)))
      else $error("heap write outside sift-up");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CMP) && key_less && (up != '0)) |-> (mem_waddr != mem_raddr))
      else $error("sift-up read and write hit the same slot");

   a_root_place: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PLACE) && (slot_ff == '0)) |=> (top_ff == $past(key_ff)))
      else $error("root copy not updated");

endmodule

### sv/mhi_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mhi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/max_heap_insert_checker.sv
`timescale 1ns / 1ps
// max-heap insert checker: follows both channels, predicts every result, compares in order
// depends on mhi_pkg; instantiated next to the engine by tb_max_heap_insert_engine_unit
module max_heap_insert_checker
   import mhi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  mhi_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  mhi_rsp_type rsp_data,
   output int          mismatch_count,
   output int          waiting_count
);

   localparam int unsigned HEAP_ARITY = 2;
   localparam int          PRINT_LIMIT = 40;

   logic signed [KEY_W-1:0] heap_model [CAPACITY];
   int unsigned             heap_size;
   mhi_rsp_type             predicted_rsp_q [$];

   // applies one request to the shadow heap and returns the result it should produce
   function automatic mhi_rsp_type heap_apply_request(input mhi_req_type req);
      mhi_rsp_type             rsp;
      int unsigned             slot;
      logic signed [KEY_W-1:0] key;
      rsp = '0;
      key = req.new_key;
      if (req.req_type == REQ_INSERT) begin
         if (heap_size < CAPACITY) begin
            slot = heap_size;
            heap_size++;
            // parents strictly smaller move down, an equal parent stays put
            while (slot > 0 && heap_model[(slot - 1) / HEAP_ARITY] < key) begin
               heap_model[slot] = heap_model[(slot - 1) / HEAP_ARITY];
               slot = (slot - 1) / HEAP_ARITY;
            end
            heap_model[slot] = key;
            rsp.accepted = 1'b1;
         end
      end else if (req.position < heap_size) begin
         rsp.accepted = 1'b1;
         rsp.read_key = heap_model[req.position];
      end
      rsp.entry_count = CNT_OUT_W'(heap_size);
      rsp.top_key     = (heap_size > 0) ? heap_model[0] : '0;
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                  input logic [KEY_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      mhi_rsp_type want;
      if (reset) begin
         predicted_rsp_q.delete();
         heap_size      = 0;
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready)
            predicted_rsp_q.push_back(heap_apply_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.read_key, '0);
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_data.accepted !== want.accepted)
                  report_mismatch("accepted", rsp_data.accepted, want.accepted);
               if (rsp_data.read_key !== want.read_key)
                  report_mismatch("read_key", rsp_data.read_key, want.read_key);
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
               if (rsp_data.top_key !== want.top_key)
                  report_mismatch("top_key", rsp_data.top_key, want.top_key);
            end
         end
      end
      waiting_count <= predicted_rsp_q.size();
   end

endmodule

### tb/sv/tb_max_heap_insert_engine_unit.sv
`timescale 1ns / 1ps
// top of the max-heap insert engine bench: clock, reset, request stimulus, result stalls, verdict
// depends on mhi_pkg, max_heap_insert_engine_unit and max_heap_insert_checker
module tb_max_heap_insert_engine_unit;
   import mhi_pkg::*;

   localparam int RUN_ITEMS    = 1500;
   localparam int IDLE_PERCENT = 26;
   localparam int DRAIN_CYCLES = 20;
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   mhi_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   mhi_rsp_type rsp_data;
   logic        steady = 1'b0;
   int          mismatch_count;
   int          waiting_count;

   max_heap_insert_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   max_heap_insert_checker heap_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // mostly full-range keys, with extremes and a narrow band that gives duplicates
   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(9))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2:       return KEY_W'($urandom_range(7));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   function automatic mhi_req_type make_insert(input logic signed [KEY_W-1:0] key);
      mhi_req_type req;
      req.req_type = REQ_INSERT;
      req.new_key  = key;
      req.position = POS_W'($urandom);
      return req;
   endfunction

   function automatic mhi_req_type make_read(input int unsigned pos);
      mhi_req_type req;
      req.req_type = REQ_READ;
      req.new_key  = KEY_W'($urandom);
      req.position = POS_W'(pos);
      return req;
   endfunction

   task automatic send_item(input mhi_req_type item);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reads on an empty heap are refused
      send_item(make_read(0));
      send_item(make_read(15));
      // extremes, equal keys, and keys that climb all the way to the root
      send_item(make_insert(KEY_MIN));
      send_item(make_insert(-1));
      send_item(make_insert(0));
      send_item(make_insert(5));
      send_item(make_insert(5));
      send_item(make_insert(3));
      send_item(make_insert(5));
      send_item(make_insert(100));
      send_item(make_insert(7));
      send_item(make_insert(KEY_MAX));
      send_item(make_read(0));
      send_item(make_read(4));
      send_item(make_read(9));
      send_item(make_read(10));
      send_item(make_read(15));

      // the heap fills within the first few inserts, after that inserts are refused
      for (int i = 0; i < RUN_ITEMS; i++) begin
         steady <= (i >= 600 && i < 900);
         if ($urandom_range(99) < 30)
            send_item(make_insert(random_key()));
         else
            send_item(make_read($urandom_range(15)));
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (waiting_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && waiting_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
